/* rtl/bdms_pkg.sv */
`default_nettype none
package bdms_pkg;

    localparam int COUNT_WIDTH = 11;
    localparam int NUM_BUTTONS = 5;
    localparam int THR_WIDTH   = 10;
    localparam int MODE_WIDTH  = 8;
    localparam int TOG_WIDTH   = 2;
    localparam int ADDR_WIDTH  = 4;
    localparam int DATA_WIDTH  = 32;

    localparam logic [THR_WIDTH-1:0]  THR_RESET    = 10'd100;
    localparam logic [MODE_WIDTH-1:0] MODE_W_RESET = 8'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_Z_RESET = 8'd2;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_MODE_W_MAX = 2'd1,
        REG_MODE_Z_MAX = 2'd2,
        REG_NONE = 2'd3
    } t_reg_idx;

    // buttons whose action clears the counter on firing
    localparam logic [NUM_BUTTONS-1:0] AUTO_CLEAR_MASK = 5'b11110;

    localparam int BTN_MODE_W = 1;
    localparam int BTN_TOG_A  = 2;
    localparam int BTN_TOG_B  = 3;
    localparam int BTN_MODE_Z = 4;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode_w;
        logic [MODE_WIDTH-1:0] mode_z;
        logic [TOG_WIDTH-1:0]  toggle_count;
    } t_result;

endpackage
`default_nettype wire

/* rtl/bdms_lane.sv */
`default_nettype none
module bdms_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_level,
    input  wire logic                           i_auto_clear,
    input  wire logic [bdms_pkg::THR_WIDTH-1:0] i_threshold,
    output logic                                o_fire
);

    logic [bdms_pkg::COUNT_WIDTH-1:0] r_count;
    logic [bdms_pkg::COUNT_WIDTH-1:0] n_count;
    logic [bdms_pkg::COUNT_WIDTH-1:0] c_inc;
    logic [bdms_pkg::COUNT_WIDTH-1:0] c_clr;

    always_comb begin
        // pressed is low; saturate at the ceiling
        if (!i_level && (r_count != {bdms_pkg::COUNT_WIDTH{1'b1}})) begin
            c_inc = r_count + 1'b1;
        end else begin
            c_inc = r_count;
        end
        o_fire = c_inc > bdms_pkg::COUNT_WIDTH'(i_threshold);
        c_clr  = (o_fire && i_auto_clear) ? '0 : c_inc;
        if (i_level && (c_clr != '0)) begin
            n_count = c_clr - 1'b1;
        end else begin
            n_count = c_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/bdms_merge.sv */
`default_nettype none
module bdms_merge (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic [bdms_pkg::NUM_BUTTONS-1:0] i_fire,
    input  wire logic [bdms_pkg::MODE_WIDTH-1:0]  i_mode_w_max,
    input  wire logic [bdms_pkg::MODE_WIDTH-1:0]  i_mode_z_max,
    output bdms_pkg::t_result                     o_result
);

    logic [bdms_pkg::MODE_WIDTH-1:0] r_mode_w;
    logic [bdms_pkg::MODE_WIDTH-1:0] r_mode_z;
    logic [bdms_pkg::MODE_WIDTH-1:0] w1;
    logic [bdms_pkg::MODE_WIDTH-1:0] z1;
    logic [bdms_pkg::MODE_WIDTH-1:0] n_mode_w;
    logic [bdms_pkg::MODE_WIDTH-1:0] n_mode_z;
    logic [bdms_pkg::MODE_WIDTH:0]   w_inc;
    logic [bdms_pkg::MODE_WIDTH:0]   z_inc;

    always_comb begin
        // mode w advance, then both modes checked against their maxima
        w_inc = {1'b0, r_mode_w} + 1'b1;
        if (i_fire[bdms_pkg::BTN_MODE_W]) begin
            w1 = (w_inc > {1'b0, i_mode_w_max}) ? '0 : w_inc[bdms_pkg::MODE_WIDTH-1:0];
            z1 = (r_mode_z > i_mode_z_max) ? '0 : r_mode_z;
        end else begin
            w1 = r_mode_w;
            z1 = r_mode_z;
        end
        // mode z advance follows in button order
        z_inc = {1'b0, z1} + 1'b1;
        if (i_fire[bdms_pkg::BTN_MODE_Z]) begin
            n_mode_z = (z_inc > {1'b0, i_mode_z_max}) ? '0 : z_inc[bdms_pkg::MODE_WIDTH-1:0];
            n_mode_w = (w1 > i_mode_w_max) ? '0 : w1;
        end else begin
            n_mode_z = z1;
            n_mode_w = w1;
        end
        o_result.mode_w       = n_mode_w;
        o_result.mode_z       = n_mode_z;
        o_result.toggle_count = bdms_pkg::TOG_WIDTH'(i_fire[bdms_pkg::BTN_TOG_A])
                              + bdms_pkg::TOG_WIDTH'(i_fire[bdms_pkg::BTN_TOG_B]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_w <= '0;
            r_mode_z <= '0;
        end else if (i_en) begin
            r_mode_w <= n_mode_w;
            r_mode_z <= n_mode_z;
        end
    end

endmodule
`default_nettype wire

/* rtl/button_debounce_mode_selector.sv */
`default_nettype none
// Five-button integrating debouncer with two wrapping mode counters. One item
// (a tick of five active-low button levels) is taken every cycle while o_ready
// is high: five counter lanes work side by side and a merge stage applies the
// mode advances in button order and counts strip toggles. The result is held in
// an output register backed by a one-entry skid buffer, so a stalled output
// costs at most one extra item before o_ready drops. Registers (threshold, mode
// W max, mode Z max) sit at byte addresses 0, 4 and 8; the user must write them
// while no item is in flight, as the block itself does not enforce this.
module button_debounce_mode_selector (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [bdms_pkg::NUM_BUTTONS-1:0] i_button_levels,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [bdms_pkg::MODE_WIDTH-1:0]       o_mode_w,
    output logic [bdms_pkg::MODE_WIDTH-1:0]       o_mode_z,
    output logic [bdms_pkg::TOG_WIDTH-1:0]        o_toggle_count,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bdms_pkg::ADDR_WIDTH-1:0]  paddr,
    input  wire logic [bdms_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [bdms_pkg::DATA_WIDTH-1:0]       prdata,
    output logic                                  pready
);

    logic [bdms_pkg::THR_WIDTH-1:0]   r_threshold;
    logic [bdms_pkg::MODE_WIDTH-1:0]  r_mode_w_max;
    logic [bdms_pkg::MODE_WIDTH-1:0]  r_mode_z_max;
    logic                             wr_en;
    bdms_pkg::t_reg_idx               reg_idx;

    logic                             in_fire;
    logic                             out_fire;
    logic [bdms_pkg::NUM_BUTTONS-1:0] fire;
    bdms_pkg::t_result                result;

    logic                             r_valid;
    bdms_pkg::t_result                r_out;
    logic                             r_skid_valid;
    bdms_pkg::t_result                r_skid;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = bdms_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= bdms_pkg::THR_RESET;
            r_mode_w_max <= bdms_pkg::MODE_W_RESET;
            r_mode_z_max <= bdms_pkg::MODE_Z_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                bdms_pkg::REG_THRESHOLD:  r_threshold  <= pwdata[bdms_pkg::THR_WIDTH-1:0];
                bdms_pkg::REG_MODE_W_MAX: r_mode_w_max <= pwdata[bdms_pkg::MODE_WIDTH-1:0];
                bdms_pkg::REG_MODE_Z_MAX: r_mode_z_max <= pwdata[bdms_pkg::MODE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bdms_pkg::REG_THRESHOLD:  prdata = bdms_pkg::DATA_WIDTH'(r_threshold);
            bdms_pkg::REG_MODE_W_MAX: prdata = bdms_pkg::DATA_WIDTH'(r_mode_w_max);
            bdms_pkg::REG_MODE_Z_MAX: prdata = bdms_pkg::DATA_WIDTH'(r_mode_z_max);
            default:                  prdata = '0;
        endcase
    end

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_valid && i_ready;

    for (genvar g = 0; g < bdms_pkg::NUM_BUTTONS; g++) begin : g_lane
        bdms_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (in_fire),
            .i_level      (i_button_levels[g]),
            .i_auto_clear (bdms_pkg::AUTO_CLEAR_MASK[g]),
            .i_threshold  (r_threshold),
            .o_fire       (fire[g])
        );
    end

    bdms_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_fire),
        .i_fire       (fire),
        .i_mode_w_max (r_mode_w_max),
        .i_mode_z_max (r_mode_z_max),
        .o_result     (result)
    );

    // output register with skid: the skid only fills while the output stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || out_fire) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_fire) begin
            r_skid <= result;
        end
    end

    assign o_valid        = r_valid;
    assign o_mode_w       = r_out.mode_w;
    assign o_mode_z       = r_out.mode_z;
    assign o_toggle_count = r_out.toggle_count;

endmodule
`default_nettype wire

/* rtl/bdms_checker.sv */
`default_nettype none
module bdms_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_ready,
    input wire logic                             o_valid,
    input wire logic                             i_ready,
    input wire logic [bdms_pkg::MODE_WIDTH-1:0]  o_mode_w,
    input wire logic [bdms_pkg::MODE_WIDTH-1:0]  o_mode_z,
    input wire logic [bdms_pkg::TOG_WIDTH-1:0]   o_toggle_count,
    input wire logic                             pready
);

    // nothing is held right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && o_ready)
        else $error("output not empty after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mode_w) && $stable(o_mode_z)
            && $stable(o_toggle_count))
        else $error("stalled result changed");

    // the skid only fills behind a held output
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with output empty");

    // only buttons 2 and 3 toggle the strip
    a_toggle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_toggle_count != 2'd3)
        else $error("toggle count out of range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind button_debounce_mode_selector bdms_checker u_bdms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_mode_w       (o_mode_w),
    .o_mode_z       (o_mode_z),
    .o_toggle_count (o_toggle_count),
    .pready         (pready)
);
`default_nettype wire

/* tb/button_debounce_mode_selector_test.sv */
module button_debounce_mode_selector_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int SENDER        = 0;
    localparam int RECEIVER      = 1;
    localparam int PRESSURE_AT   = 200;
    localparam int PRESSURE_HOLD = 90;

    class debounce_ledger;
        logic [bdms_pkg::COUNT_WIDTH-1:0] counts [bdms_pkg::NUM_BUTTONS];
        logic [bdms_pkg::MODE_WIDTH-1:0]  mode_w;
        logic [bdms_pkg::MODE_WIDTH-1:0]  mode_z;
        logic [bdms_pkg::THR_WIDTH-1:0]   thr;
        logic [bdms_pkg::MODE_WIDTH-1:0]  w_max;
        logic [bdms_pkg::MODE_WIDTH-1:0]  z_max;
        bdms_pkg::t_result                awaited [$];
        int                               failures;
        int                               results_seen;

        function new();
            foreach (counts[b])
                counts[b] = '0;
            mode_w = '0;
            mode_z = '0;
            thr = bdms_pkg::THR_RESET;
            w_max = bdms_pkg::MODE_W_RESET;
            z_max = bdms_pkg::MODE_Z_RESET;
            failures = 0;
            results_seen = 0;
        endfunction

        function void write_reg(bdms_pkg::t_reg_idx idx,
                                logic [bdms_pkg::DATA_WIDTH-1:0] data);
            case (idx)
                bdms_pkg::REG_THRESHOLD: thr = data[bdms_pkg::THR_WIDTH-1:0];
                bdms_pkg::REG_MODE_W_MAX: w_max = data[bdms_pkg::MODE_WIDTH-1:0];
                bdms_pkg::REG_MODE_Z_MAX: z_max = data[bdms_pkg::MODE_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        // both modes are rechecked against their maximums on any advance
        function void advance_mode(bit on_z);
            logic [bdms_pkg::MODE_WIDTH:0] w;
            logic [bdms_pkg::MODE_WIDTH:0] z;
            w = {1'b0, mode_w};
            z = {1'b0, mode_z};
            if (on_z)
                z = z + 1'b1;
            else
                w = w + 1'b1;
            if (z > {1'b0, z_max})
                z = '0;
            if (w > {1'b0, w_max})
                w = '0;
            mode_w = w[bdms_pkg::MODE_WIDTH-1:0];
            mode_z = z[bdms_pkg::MODE_WIDTH-1:0];
        endfunction

        function void note_tick(logic [bdms_pkg::NUM_BUTTONS-1:0] levels);
            logic [bdms_pkg::COUNT_WIDTH-1:0] c;
            logic [bdms_pkg::TOG_WIDTH-1:0]   toggles;
            bdms_pkg::t_result                r;
            toggles = '0;
            for (int b = 0; b < bdms_pkg::NUM_BUTTONS; b++) begin
                c = counts[b];
                if (!levels[b] && c != '1)
                    c = c + 1'b1;
                if (c > {1'b0, thr}) begin
                    if (b == bdms_pkg::BTN_MODE_W) begin
                        advance_mode(1'b0);
                        c = '0;
                    end else if (b == bdms_pkg::BTN_MODE_Z) begin
                        advance_mode(1'b1);
                        c = '0;
                    end else if (b == bdms_pkg::BTN_TOG_A || b == bdms_pkg::BTN_TOG_B) begin
                        toggles = toggles + 1'b1;
                        c = '0;
                    end
                end
                if (c != '0 && levels[b])
                    c = c - 1'b1;
                counts[b] = c;
            end
            r.mode_w = mode_w;
            r.mode_z = mode_z;
            r.toggle_count = toggles;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [bdms_pkg::MODE_WIDTH-1:0] w,
                                   logic [bdms_pkg::MODE_WIDTH-1:0] z,
                                   logic [bdms_pkg::TOG_WIDTH-1:0] t);
            bdms_pkg::t_result e;
            results_seen++;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: mode_w %0d mode_z %0d toggles %0d",
                       w, z, t);
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (w !== e.mode_w) begin
                $error("mode_w: expected %0d, got %0d", e.mode_w, w);
                failures++;
            end
            if (z !== e.mode_z) begin
                $error("mode_z: expected %0d, got %0d", e.mode_z, z);
                failures++;
            end
            if (t !== e.toggle_count) begin
                $error("toggle_count: expected %0d, got %0d", e.toggle_count, t);
                failures++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [bdms_pkg::NUM_BUTTONS-1:0] i_button_levels;
    logic                             o_valid;
    logic                             i_ready;
    logic [bdms_pkg::MODE_WIDTH-1:0]  o_mode_w;
    logic [bdms_pkg::MODE_WIDTH-1:0]  o_mode_z;
    logic [bdms_pkg::TOG_WIDTH-1:0]   o_toggle_count;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [bdms_pkg::ADDR_WIDTH-1:0]  paddr;
    logic [bdms_pkg::DATA_WIDTH-1:0]  pwdata;
    logic [bdms_pkg::DATA_WIDTH-1:0]  prdata;
    logic                             pready;

    debounce_ledger                   ledger = new();
    int                               zero_run [2] = '{0, 0};
    logic [bdms_pkg::NUM_BUTTONS-1:0] held_down = '0;

    button_debounce_mode_selector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_button_levels(i_button_levels),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mode_w       (o_mode_w),
        .o_mode_z       (o_mode_z),
        .o_toggle_count (o_toggle_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly random gaps, with occasional runs of back-to-back items
    function automatic int draw_gap(input int side);
        if (zero_run[side] > 0) begin
            zero_run[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            zero_run[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // buttons stay held or released for runs, plus some single-tick bounce
    function automatic logic [bdms_pkg::NUM_BUTTONS-1:0] next_levels(input int flip_pct);
        logic [bdms_pkg::NUM_BUTTONS-1:0] lv;
        int                               bit_idx;
        for (int b = 0; b < bdms_pkg::NUM_BUTTONS; b++)
            if ($urandom_range(0, 99) < flip_pct)
                held_down[b] = ~held_down[b];
        lv = ~held_down;
        if ($urandom_range(0, 19) == 0) begin
            bit_idx = $urandom_range(0, bdms_pkg::NUM_BUTTONS - 1);
            lv[bit_idx] = ~lv[bit_idx];
        end
        return lv;
    endfunction

    task automatic send_tick(input logic [bdms_pkg::NUM_BUTTONS-1:0] levels);
        int gap;
        gap = draw_gap(SENDER);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_button_levels <= levels;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        ledger.note_tick(levels);
    endtask

    task automatic write_reg(input bdms_pkg::t_reg_idx idx,
                             input logic [bdms_pkg::DATA_WIDTH-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ledger.write_reg(idx, data);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (ledger.awaited.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // upper bits carry junk that the block must mask off
    task automatic program_regs(input int thr, input int w_max, input int z_max);
        drain();
        write_reg(bdms_pkg::REG_THRESHOLD,
                  (32'($urandom) << bdms_pkg::THR_WIDTH) | 32'(thr));
        write_reg(bdms_pkg::REG_MODE_W_MAX,
                  (32'($urandom) << bdms_pkg::MODE_WIDTH) | 32'(w_max));
        write_reg(bdms_pkg::REG_MODE_Z_MAX,
                  (32'($urandom) << bdms_pkg::MODE_WIDTH) | 32'(z_max));
        write_reg(bdms_pkg::REG_NONE, 32'($urandom));
    endtask

    task automatic run_phase(input int thr, input int w_max, input int z_max,
                             input int count, input int flip_pct,
                             input logic [bdms_pkg::NUM_BUTTONS-1:0] pinned);
        program_regs(thr, w_max, z_max);
        repeat (count)
            send_tick(next_levels(flip_pct) & ~pinned);
    endtask

    initial begin : receiver
        int gap;
        do
            @(posedge i_clk);
        while (!i_rst_n);
        forever begin
            gap = draw_gap(RECEIVER);
            // long hold-off so the block backs up into its input
            if (ledger.results_seen == PRESSURE_AT)
                gap = PRESSURE_HOLD;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            ledger.check_result(o_mode_w, o_mode_z, o_toggle_count);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("button_debounce_mode_selector_test failed");
        $finish;
    end

    initial begin : stimulus
        logic [bdms_pkg::NUM_BUTTONS-1:0] fast_fire [10];
        logic [bdms_pkg::NUM_BUTTONS-1:0] two_tick [6];
        fast_fire = '{5'b00000, 5'b00000, 5'b00000, 5'b11101, 5'b01111,
                      5'b11011, 5'b10111, 5'b11110, 5'b11111, 5'b00000};
        two_tick = '{5'b00000, 5'b00000, 5'b00000, 5'b11111, 5'b00000, 5'b11111};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_button_levels = '1;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: nothing fires yet
        send_tick(5'b11111);
        send_tick(5'b00000);
        // threshold zero: every pressed tick fires
        program_regs(0, 2, 1);
        foreach (fast_fire[k])
            send_tick(fast_fire[k]);
        // two pressed ticks needed, both modes pinned at zero
        program_regs(1, 0, 0);
        foreach (two_tick[k])
            send_tick(two_tick[k]);

        for (int p = 0; p < 4; p++)
            run_phase($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 5),
                      80, 10, '0);
        // buttons 1 and 4 held: modes climb to 255 and wrap to zero
        run_phase(0, 255, 255, 270, 10, 5'b10010);
        // modes now sit above the lowered maximums until the next advance
        run_phase(20, 5, 7, 60, 8, '0);
        // top threshold: held buttons count up without firing
        run_phase(1023, 128, 64, 40, 3, 5'b11011);

        drain();
        repeat (8) @(posedge i_clk);
        if (ledger.failures == 0)
            $display("button_debounce_mode_selector_test passed");
        else
            $display("button_debounce_mode_selector_test failed");
        $finish;
    end

endmodule

/* button_debounce_mode_selector.f */
rtl/bdms_pkg.sv
rtl/bdms_lane.sv
rtl/bdms_merge.sv
rtl/button_debounce_mode_selector.sv
rtl/bdms_checker.sv
tb/button_debounce_mode_selector_test.sv
